// ===== sv/fbe_pkg.sv =====
// fbe_pkg: shared types and constants for the feedback echo delay block.
// No dependencies.
package fbe_pkg;

	typedef logic signed [15:0] sample_t;
	typedef logic [7:0]         gain_t;
	typedef logic [1:0]         reg_idx_t;

	localparam reg_idx_t REG_FEEDBACK_GAIN = 2'd0;
	localparam reg_idx_t REG_DELAY_TIME    = 2'd1;
	localparam reg_idx_t REG_WET_LEVEL     = 2'd2;

	localparam gain_t GAIN_FULL = 8'd255;
	localparam logic signed [17:0] SAT_POS = 18'sd32767;
	localparam logic signed [17:0] SAT_NEG = -18'sd32767;

endpackage

// ===== sv/feedback_echo_delay.sv =====
// feedback_echo_delay: feedback echo over a circular delay memory.
// Depends on fbe_pkg.
// Each sample passes through accept, multiply, memory write/read, mix and
// output load in turn (S_IDLE, S_MUL, S_WR, S_MIX, S_OUT), one at a time:
// a new sample is accepted only in S_IDLE, after the last result is loaded;
// S_OUT waits while the output register still holds an unaccepted result.
// Reset clears pointer, fill count, feedback sample and registers; the
// memory is not cleared, entries beyond the fill count read as zero.
module feedback_echo_delay #(
	parameter int unsigned BUFFER_DEPTH = 65536,
	parameter int unsigned MAX_DELAY    = 40000
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  fbe_pkg::reg_idx_t     cfg_index,
	input  fbe_pkg::gain_t        cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,   // [15:0] sample_in
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata    // [15:0] sample_out
);
	import fbe_pkg::*;

	localparam int unsigned PW = $clog2(BUFFER_DEPTH);
	localparam logic [16:0] DEPTH17 = 17'(BUFFER_DEPTH);
	localparam logic [15:0] MAXD = 16'(MAX_DELAY);
	localparam logic [PW-1:0] WP_LAST = PW'(BUFFER_DEPTH - 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_WR   = 3'd2;
	localparam logic [2:0] S_MIX  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]   state_q;
	gain_t        fb_gain_q, delay_time_q, wet_level_q;
	logic [PW-1:0] wp_q;
	logic [16:0]  fill_q;
	sample_t      prev_q;
	sample_t      dry_q;

	logic signed [24:0] fb_prod_s1;
	logic [23:0]        off_prod_s1;

	sample_t      stored_s2;
	logic         hit_s2, fwd_s2;
	sample_t      rd_s2;

	logic signed [24:0] dry_prod_s3, wet_prod_s3;

	logic         out_valid_q;
	sample_t      out_data_q;

	sample_t      mem [BUFFER_DEPTH];

	// write/read address generation, feedback sum, mix and saturation
	logic signed [16:0] fb_shift;
	sample_t      stored_w;
	logic [16:0]  off_raw, off_w, wp17, rp17, fill_new;
	logic [PW-1:0] rp_w;
	sample_t      delayed_w;
	logic signed [17:0] mix_w;
	sample_t      sat_w;

	assign fb_shift = 17'(fb_prod_s1 >>> 8);
	assign stored_w = 16'(dry_q + fb_shift);
	assign off_raw  = {1'b0, off_prod_s1[23:8]};
	assign off_w    = (off_raw >= DEPTH17) ? off_raw - DEPTH17 : off_raw;
	assign wp17     = 17'(wp_q);
	assign rp17     = (wp17 >= off_w) ? wp17 - off_w : wp17 + DEPTH17 - off_w;
	assign rp_w     = rp17[PW-1:0];
	assign fill_new = (fill_q == DEPTH17) ? fill_q : fill_q + 17'd1;

	assign delayed_w = !hit_s2 ? '0 : (fwd_s2 ? stored_s2 : rd_s2);

	assign mix_w = 18'(dry_prod_s3 >>> 8) + 18'(wet_prod_s3 >>> 8);
	assign sat_w = (mix_w > SAT_POS) ? 16'(SAT_POS) :
	               (mix_w < SAT_NEG) ? 16'(SAT_NEG) : 16'(mix_w);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_gain_q    <= '0;
			delay_time_q <= '0;
			wet_level_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FEEDBACK_GAIN: fb_gain_q    <= cfg_data;
				REG_DELAY_TIME:    delay_time_q <= cfg_data;
				REG_WET_LEVEL:     wet_level_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wp_q        <= '0;
			fill_q      <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid)
						state_q <= S_MUL;
				end
				S_MUL: state_q <= S_WR;
				S_WR: begin
					fill_q  <= fill_new;
					wp_q    <= (wp_q == WP_LAST) ? '0 : wp_q + PW'(1);
					state_q <= S_MIX;
				end
				S_MIX: begin
					prev_q  <= delayed_w;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			dry_q <= sample_t'(s_tdata);
		if (state_q == S_MUL) begin
			fb_prod_s1  <= prev_q * $signed({1'b0, fb_gain_q});
			off_prod_s1 <= 24'(MAXD) * 24'(GAIN_FULL - delay_time_q);
		end
		if (state_q == S_WR) begin
			stored_s2 <= stored_w;
			fwd_s2    <= (off_w == 17'd0);
			hit_s2    <= (off_w < fill_new);
		end
		if (state_q == S_MIX) begin
			dry_prod_s3 <= dry_q * $signed({1'b0, GAIN_FULL - wet_level_q});
			wet_prod_s3 <= delayed_w * $signed({1'b0, wet_level_q});
		end
		if (state_q == S_OUT && (!out_valid_q || m_tready))
			out_data_q <= sat_w;
	end

	// delay memory: write and read in the same cycle, read-before-write
	always_ff @(posedge clk) begin
		if (state_q == S_WR) begin
			mem[wp_q] <= stored_w;
			rd_s2     <= mem[rp_w];
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH17)
		else $error("fill count beyond memory depth");

	a_ptr_tracks_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q < DEPTH17) |-> (wp17 == fill_q))
		else $error("write pointer out of step with fill count");

	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_MUL) ##1 (state_q == S_WR))
		else $error("sample sequence broken");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata != 16'h8000))
		else $error("output outside saturation range");

endmodule

// ===== sim/tb_feedback_echo_delay.sv =====
// tb_feedback_echo_delay: self-checking bench for the feedback echo block; a
// sample-accurate echo predictor runs beside the block and checks every output.
// Depends on fbe_pkg and feedback_echo_delay.
module tb_feedback_echo_delay;
	import fbe_pkg::*;

	localparam int unsigned ECHO_DEPTH  = 65536;
	localparam int unsigned ECHO_MAX    = 40000;
	localparam int          HOLD_CYCLES = 300;
	localparam int          CYCLE_LIMIT = 200000;
	localparam reg_idx_t    REG_SPARE   = 2'd3;

	logic     clk;
	logic     arst_n;
	logic     cfg_valid;
	logic     cfg_ready;
	reg_idx_t cfg_index;
	gain_t    cfg_data;
	logic     s_tvalid;
	logic     s_tready;
	logic [15:0] s_tdata;
	logic     m_tvalid;
	logic     m_tready;
	logic [15:0] m_tdata;

	// predictor state
	sample_t echo_mem [ECHO_DEPTH];
	logic [15:0] wr_ptr;
	sample_t last_delayed;
	gain_t   fb_gain;
	gain_t   dly_time;
	gain_t   wet_mix;

	sample_t sample_queue [$];
	sample_t expected_out [$];

	int send_gap_pct;
	int recv_stall_pct;
	int error_count;
	int samples_sent;
	int results_checked;
	int settings_run;
	int cycle_count;

	logic hold_req;
	logic hold_ack;
	int   hold_left;

	sample_t corner_samples [12] = '{
		16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, -16'sh8000,
		16'sh0000, 16'sh0001, -16'sh0001, 16'sh5555, 16'shAAAA, 16'sh7FFF
	};

	feedback_echo_delay i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// one input sample in, one mixed sample out; updates the echo state
	function automatic sample_t echo_step(sample_t dry_in);
		int dry_i;
		int gain_i;
		int wet_i;
		int fb_i;
		int delayed_i;
		int mix_i;
		int unsigned off;
		logic [15:0] rd_ptr;
		sample_t stored;
		dry_i = dry_in;
		gain_i = fb_gain;
		wet_i = wet_mix;
		fb_i = (int'(last_delayed) * gain_i) >>> 8;
		stored = sample_t'(dry_i + fb_i);
		off = ((ECHO_MAX * (int'(GAIN_FULL) - int'(dly_time))) >> 8) % ECHO_DEPTH;
		rd_ptr = wr_ptr - off[15:0];
		echo_mem[wr_ptr] = stored;
		delayed_i = echo_mem[rd_ptr];
		wr_ptr = wr_ptr + 16'd1;
		mix_i = ((dry_i * (int'(GAIN_FULL) - wet_i)) >>> 8) + ((delayed_i * wet_i) >>> 8);
		if (mix_i > SAT_POS)
			mix_i = SAT_POS;
		else if (mix_i < SAT_NEG)
			mix_i = SAT_NEG;
		last_delayed = sample_t'(delayed_i);
		return sample_t'(mix_i);
	endfunction

	function automatic sample_t rand_sample();
		case ($urandom_range(9))
			0: return 16'sh7FFF;
			1: return -16'sh8000;
			2: return sample_t'($urandom_range(255)) - 16'sd128;
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t mismatch: %s", $time, msg);
		error_count++;
	endtask

	// input side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (sample_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				s_tvalid <= 1'b1;
				s_tdata  <= sample_queue.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// long output hold-off, requested by toggling hold_req
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_ack  <= 1'b0;
		end else if (hold_req != hold_ack) begin
			hold_left <= HOLD_CYCLES;
			hold_ack  <= hold_req;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// output side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else if (hold_left != 0 || hold_req != hold_ack)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// predictor and checker
	always @(posedge clk) begin
		if (arst_n) begin
			sample_t want;
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("status: fail");
				$finish;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FEEDBACK_GAIN: fb_gain  = cfg_data;
					REG_DELAY_TIME:    dly_time = cfg_data;
					REG_WET_LEVEL:     wet_mix  = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				expected_out.push_back(echo_step(sample_t'(s_tdata)));
				samples_sent++;
			end
			if (m_tvalid && m_tready) begin
				if (expected_out.size() == 0) begin
					report_mismatch($sformatf("unexpected output %0d",
						sample_t'(m_tdata)));
				end else begin
					want = expected_out.pop_front();
					results_checked++;
					if (sample_t'(m_tdata) !== want)
						report_mismatch($sformatf("sample_out %0d, expected %0d",
							sample_t'(m_tdata), want));
				end
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, gain_t val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (sample_queue.size() != 0 || s_tvalid || expected_out.size() != 0);
	endtask

	task automatic run_phase(gain_t fb, gain_t dt, gain_t wet, int gap_pct,
			int stall_pct, int count, bit hold);
		write_reg(REG_FEEDBACK_GAIN, fb);
		write_reg(REG_DELAY_TIME, dt);
		write_reg(REG_WET_LEVEL, wet);
		@(negedge clk);
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		settings_run++;
		for (int i = 0; i < count; i++)
			sample_queue.push_back(rand_sample());
		if (hold)
			hold_req = ~hold_req;
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_FEEDBACK_GAIN;
		cfg_data  <= '0;
		hold_req = 1'b0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		error_count = 0;
		samples_sent = 0;
		results_checked = 0;
		settings_run = 0;
		cycle_count = 0;
		for (int i = 0; i < ECHO_DEPTH; i++)
			echo_mem[i] = '0;
		wr_ptr = '0;
		last_delayed = '0;
		fb_gain = '0;
		dly_time = '0;
		wet_mix = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero offset, full feedback, full wet: stored sum wraps on repeated peaks
		write_reg(REG_SPARE, 8'hFF);
		write_reg(REG_FEEDBACK_GAIN, GAIN_FULL);
		write_reg(REG_DELAY_TIME, GAIN_FULL);
		write_reg(REG_WET_LEVEL, GAIN_FULL);
		@(negedge clk);
		settings_run++;
		foreach (corner_samples[i])
			sample_queue.push_back(corner_samples[i]);
		wait_drained();

		run_phase(8'd0, 8'd0, 8'd0, 51, 0, 150, 1'b0);
		run_phase(8'($urandom), 8'($urandom_range(252, 255)), 8'($urandom),
			0, 51, 250, 1'b0);
		run_phase(8'hAA, 8'd254, 8'h55, 0, 0, 100, 1'b1);
		run_phase(8'($urandom), 8'($urandom_range(250, 255)), 8'($urandom),
			22, 22, 300, 1'b0);
		write_reg(REG_SPARE, 8'h00);
		run_phase(GAIN_FULL, 8'd254, 8'd128, 0, 0, 200, 1'b0);
		run_phase(8'($urandom), 8'($urandom), 8'($urandom), 22, 22, 200, 1'b0);

		repeat (10) @(posedge clk);
		if (expected_out.size() != 0)
			report_mismatch($sformatf("%0d outputs never arrived", expected_out.size()));
		$display("%0d samples sent, %0d outputs checked over %0d register settings",
			samples_sent, results_checked, settings_run);
		$display("covered zero and full-length delays, wrapping feedback, stalls and a long hold-off");
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
